/* rtl/core/ptle_pkg.sv */
// ----------------------------------------------------------------------------
// ptle_pkg
// Shared types and constants of the page table lookup engine.
// ----------------------------------------------------------------------------
package ptle_pkg;

    localparam int MODE_W      = 3;
    localparam int PAGE_W      = 10;
    localparam int FRAME_W     = 10;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 32;
    localparam int FRAME_SPACE = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP    = 3'd0,
        MODE_SET_VALID = 3'd1,
        MODE_SET_DIRTY = 3'd2,
        MODE_SET_FRAME = 3'd3,
        MODE_ALLOC     = 3'd4,
        MODE_READ      = 3'd5
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PAGE_W-1:0]  page;
        logic               flag;
        logic [FRAME_W-1:0] frame;
    } req_t;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   stamp;
    } entry_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic               alloc_ok;
        logic               valid_out;
        logic               dirty_out;
        logic [CNT_W-1:0]   last_used_out;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [CNT_W-1:0]   ref_total;
        logic [CNT_W-1:0]   ordinal_now;
    } result_t;

endpackage

/* rtl/core/page_table_lookup_engine.sv */
// ----------------------------------------------------------------------------
// page_table_lookup_engine
// Single-level page table: lookup, entry update, entry read and frame
// allocation, with hit, miss and reference counters.
// ----------------------------------------------------------------------------
// Each request is read from the table memory in its transfer cycle, whose read
// data is registered; in the next cycle the entry is modified, written back and
// the result is loaded into the output register. A new request is taken once
// the last one has left the modify cycle, also while that result still waits
// for its transfer; the modify cycle holds until the output register is free.
// After reset a clearing pass zeroes the table, one entry per cycle; no request
// is taken until it ends. Configuration writes to max_frame_count are taken at
// any time and must only happen while idle.
// Pages at or beyond NUM_PAGES read as empty entries and are never written.
// ----------------------------------------------------------------------------
module page_table_lookup_engine #(
    parameter int NUM_PAGES  = 1024,
    parameter int NUM_FRAMES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [ptle_pkg::CFG_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ptle_pkg::MODE_W-1:0]    mode,
    input  logic [ptle_pkg::PAGE_W-1:0]    page,
    input  logic                           flag,
    input  logic [ptle_pkg::FRAME_W-1:0]   frame,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic [ptle_pkg::FRAME_W-1:0]   frame_out,
    output logic                           alloc_ok,
    output logic                           valid_out,
    output logic                           dirty_out,
    output logic [ptle_pkg::CNT_W-1:0]     last_used_out,
    output logic [ptle_pkg::CNT_W-1:0]     hit_total,
    output logic [ptle_pkg::CNT_W-1:0]     miss_total,
    output logic [ptle_pkg::CNT_W-1:0]     ref_total,
    output logic [ptle_pkg::CNT_W-1:0]     ordinal_now
);
    import ptle_pkg::*;

    localparam int ADDR_W    = $clog2(NUM_PAGES);
    localparam int PW        = ADDR_W + PAGE_W;
    localparam int CFG_RESET = (NUM_FRAMES > 2047) ? 2047 : NUM_FRAMES;

    state_t            state_reg, state_next;
    req_t              req_reg;
    result_t           res_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]  max_frame_count_reg;

    logic              accept;
    logic              fire;
    logic              clear_busy;
    logic [PW-1:0]     page_wide;
    entry_t            rd_entry;
    entry_t            wr_entry;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    result_t           res;

    // Take a request only when no item is in the modify cycle and the
    // clearing pass is done.
    assign in_ready  = (state_reg == ST_IDLE) && !clear_busy;
    assign accept    = in_valid && in_ready;
    assign page_wide = {{ADDR_W{1'b0}}, page};

    // ------------------------------------------------------------------
    // Sequencer: IDLE issues the table read on the request transfer,
    // EXEC writes back and loads the output register once it is free.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        fire           = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    fire           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            out_valid_reg       <= 1'b0;
            max_frame_count_reg <= CFG_W'(CFG_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_frame_count_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the request for the modify cycle; load the result on fire.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.mode  <= mode;
            req_reg.page  <= page;
            req_reg.flag  <= flag;
            req_reg.frame <= frame;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    ptle_table #(
        .NUM_PAGES (NUM_PAGES),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (page_wide[ADDR_W-1:0]),
        .rd_data    (rd_entry),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_entry),
        .clear_busy (clear_busy)
    );

    ptle_exec #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES),
        .ADDR_W     (ADDR_W)
    ) u_exec (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .req             (req_reg),
        .rd_entry        (rd_entry),
        .max_frame_count (max_frame_count_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_entry        (wr_entry),
        .res             (res)
    );

    assign out_valid     = out_valid_reg;
    assign hit           = res_reg.hit;
    assign frame_out     = res_reg.frame_out;
    assign alloc_ok      = res_reg.alloc_ok;
    assign valid_out     = res_reg.valid_out;
    assign dirty_out     = res_reg.dirty_out;
    assign last_used_out = res_reg.last_used_out;
    assign hit_total     = res_reg.hit_total;
    assign miss_total    = res_reg.miss_total;
    assign ref_total     = res_reg.ref_total;
    assign ordinal_now   = res_reg.ordinal_now;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A request transfer always leads into the modify cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("request transfer did not enter modify cycle");

    // A write-back only ever happens in the modify cycle of a request.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (fire && (state_reg == ST_EXEC)))
        else $error("table write outside modify cycle");

    // A fired item shows up as a valid result in the next cycle.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("fired item not presented");

    // The reference counter moves only by a fired lookup.
    a_ref_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req_reg.mode != MODE_LOOKUP)) |=>
            (res_reg.ref_total == $past(u_exec.ref_cnt_reg)))
        else $error("reference count moved on non-lookup");

endmodule

/* rtl/core/ptle_table.sv */
// ----------------------------------------------------------------------------
// ptle_table
// Entry memory: one read port with registered data, one write port, and a
// clearing sweep after reset that zeroes every entry one per cycle.
// ----------------------------------------------------------------------------
module ptle_table #(
    parameter int NUM_PAGES = 1024,
    parameter int ADDR_W    = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output ptle_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  ptle_pkg::entry_t     wr_data,
    output logic                 clear_busy
);
    import ptle_pkg::*;

    entry_t              mem [NUM_PAGES];
    entry_t              rd_data_reg;
    logic                clear_busy_reg;
    logic                clear_busy_next;
    logic [ADDR_W-1:0]   clear_addr_reg;
    logic [ADDR_W-1:0]   clear_addr_next;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    entry_t              wdata;

    // Sweep owns the write port until every entry is zero.
    always_comb
    begin
        we              = wr_en;
        waddr           = wr_addr;
        wdata           = wr_data;
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            we              = 1'b1;
            waddr           = clear_addr_reg;
            wdata           = '0;
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(NUM_PAGES - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

/* rtl/core/ptle_exec.sv */
// ----------------------------------------------------------------------------
// ptle_exec
// Modify stage: turns the fetched entry and the request into the written-back
// entry and the result, and holds the counters and the frame allocator.
// ----------------------------------------------------------------------------
module ptle_exec #(
    parameter int NUM_PAGES  = 1024,
    parameter int NUM_FRAMES = 1024,
    parameter int ADDR_W     = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  ptle_pkg::req_t              req,
    input  ptle_pkg::entry_t            rd_entry,
    input  logic [ptle_pkg::CFG_W-1:0]  max_frame_count,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output ptle_pkg::entry_t            wr_entry,
    output ptle_pkg::result_t           res
);
    import ptle_pkg::*;

    localparam int PW      = ADDR_W + PAGE_W;
    localparam int LIM_CAP = (NUM_FRAMES < FRAME_SPACE) ? NUM_FRAMES : FRAME_SPACE;

    logic [CNT_W-1:0] hit_cnt_reg,  hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0] ref_cnt_reg,  ref_cnt_next;
    logic [CNT_W-1:0] ordinal_reg,  ordinal_next;
    logic [CFG_W-1:0] frames_used_reg, frames_used_next;

    logic [PW-1:0]    page_wide;
    logic             in_table;
    logic [CFG_W-1:0] limit;
    entry_t           cur;
    logic             write_req;

    assign page_wide = {{ADDR_W{1'b0}}, req.page};
    assign in_table  = page_wide < PW'(NUM_PAGES);
    assign wr_addr   = page_wide[ADDR_W-1:0];
    assign limit     = (max_frame_count < CFG_W'(LIM_CAP)) ? max_frame_count
                                                           : CFG_W'(LIM_CAP);

    always_comb
    begin
        // Pages beyond the table read as an all-zero entry.
        cur              = in_table ? rd_entry : '0;
        wr_entry         = cur;
        write_req        = 1'b0;
        res              = '0;
        hit_cnt_next     = hit_cnt_reg;
        miss_cnt_next    = miss_cnt_reg;
        ref_cnt_next     = ref_cnt_reg;
        ordinal_next     = ordinal_reg;
        frames_used_next = frames_used_reg;
        case (req.mode)
            MODE_LOOKUP:
            begin
                ref_cnt_next = ref_cnt_reg + 1'b1;
                if (cur.valid)
                begin
                    res.hit       = 1'b1;
                    res.frame_out = cur.frame;
                    hit_cnt_next  = hit_cnt_reg + 1'b1;
                end
                else
                begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
                wr_entry.stamp = ordinal_reg;
                write_req      = 1'b1;
                ordinal_next   = ordinal_reg + 1'b1;
            end
            MODE_SET_VALID:
            begin
                wr_entry.valid = req.flag;
                write_req      = 1'b1;
            end
            MODE_SET_DIRTY:
            begin
                wr_entry.dirty = req.flag;
                write_req      = 1'b1;
            end
            MODE_SET_FRAME:
            begin
                wr_entry.frame = req.frame;
                write_req      = 1'b1;
            end
            MODE_ALLOC:
            begin
                if (frames_used_reg < limit)
                begin
                    res.frame_out    = frames_used_reg[FRAME_W-1:0];
                    res.alloc_ok     = 1'b1;
                    frames_used_next = frames_used_reg + 1'b1;
                end
            end
            MODE_READ:
            begin
                res.frame_out     = cur.frame;
                res.valid_out     = cur.valid;
                res.dirty_out     = cur.dirty;
                res.last_used_out = cur.stamp;
            end
            default:
            begin
                write_req = 1'b0;
            end
        endcase
        res.hit_total   = hit_cnt_next;
        res.miss_total  = miss_cnt_next;
        res.ref_total   = ref_cnt_next;
        res.ordinal_now = ordinal_next;
    end

    assign wr_en = fire && write_req && in_table;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            ref_cnt_reg     <= '0;
            ordinal_reg     <= '0;
            frames_used_reg <= '0;
        end
        else if (fire)
        begin
            hit_cnt_reg     <= hit_cnt_next;
            miss_cnt_reg    <= miss_cnt_next;
            ref_cnt_reg     <= ref_cnt_next;
            ordinal_reg     <= ordinal_next;
            frames_used_reg <= frames_used_next;
        end
    end

endmodule
